[rtl/abd_pkg.sv]
// ----------------------------------------------------------------------------
// abd_pkg
// Shared constants, codes and controller/datapath interface types for the
// arcade board bus decoder.
// ----------------------------------------------------------------------------
package abd_pkg;

    // Memory map sizing
    localparam int ROM_BYTES       = 16384;
    localparam int ROM_ADDR_W      = $clog2(ROM_BYTES);
    localparam int RAM_DEPTH       = 4096;
    localparam int RAM_ADDR_W      = $clog2(RAM_DEPTH);
    localparam int BYTE_W          = 8;

    // Watchdog
    localparam int WATCHDOG_FRAMES = 16;
    localparam int FRAME_W         = 5;

    // Byte returned by unmapped space
    localparam logic [BYTE_W-1:0] UNMAPPED_BYTE = 8'hBF;

    // Request codes
    typedef enum logic [2:0] {
        FUNC_READ     = 3'd0,
        FUNC_WRITE    = 3'd1,
        FUNC_PORT     = 3'd2,
        FUNC_FRAME    = 3'd3,
        FUNC_ROM_LOAD = 3'd4
    } abd_func_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_DIP_ONE = 2'd0,
        CFG_DIP_TWO = 2'd1,
        CFG_WDOG_ON = 2'd2
    } abd_cfg_t;

    // Input window select, offset bits 7:6
    typedef enum logic [1:0] {
        IO_JOYSTICK = 2'd0,
        IO_START    = 2'd1,
        IO_DIP_ONE  = 2'd2,
        IO_DIP_TWO  = 2'd3
    } abd_io_sel_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2
    } abd_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // take a request, start memory reads
        logic execute;     // apply updates, load the output register
        logic clear_step;  // write one work RAM entry of the clearing sweep
    } abd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic wdog_expire; // captured request expires the watchdog
        logic clear_last;  // clearing sweep is at its last entry
    } abd_status_t;

endpackage

[rtl/abd_ram.sv]
// ----------------------------------------------------------------------------
// abd_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module abd_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/abd_ctrl.sv]
// ----------------------------------------------------------------------------
// abd_ctrl
// Controller: sequences request capture, execution and the work RAM
// clearing sweep, and owns the output valid flag.
// ----------------------------------------------------------------------------
module abd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output abd_pkg::abd_cmd_t    cmd,
    input  abd_pkg::abd_status_t stat
);
    import abd_pkg::*;

    abd_state_t state_reg;
    abd_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // State and output flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // finish only when the output register is free or draining
                if (!out_valid_reg || out_ready)
                begin
                    cmd.execute = 1'b1;
                    state_next  = stat.wdog_expire ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Output valid: set on execute, dropped when taken
    always_comb
    begin
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    // one request in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("abd_ctrl: request accepted while another is in flight");

    // a watchdog expiry starts the clearing sweep
    a_expire_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && stat.wdog_expire) |=> (cmd.clear_step && !in_ready))
        else $error("abd_ctrl: watchdog expiry did not start RAM clear");

    // every executed request produces a pending result
    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> out_valid)
        else $error("abd_ctrl: executed request left no result");
`endif

endmodule

[rtl/abd_datapath.sv]
// ----------------------------------------------------------------------------
// abd_datapath
// Datapath: request registers, address decode, program ROM and work RAM,
// control latch, vector register, watchdog counter, configuration
// registers and the result register.
// ----------------------------------------------------------------------------
module abd_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  abd_pkg::abd_cmd_t    cmd,
    output abd_pkg::abd_status_t stat,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic [2:0]           func,
    input  logic [15:0]          address,
    input  logic [7:0]           write_data,
    input  logic [7:0]           joystick_port,
    input  logic [7:0]           start_port,
    output logic [7:0]           read_data,
    output logic                 irq_request,
    output logic [7:0]           irq_vector_out,
    output logic                 cpu_reset,
    output logic [7:0]           latch_bits
);
    import abd_pkg::*;

    localparam logic [15:0] ROM_LIMIT = 16'(ROM_BYTES);

    // Captured request
    logic [2:0]        func_reg;
    logic [15:0]       addr_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] joy_reg;
    logic [BYTE_W-1:0] start_reg;

    // Board state and configuration
    logic [BYTE_W-1:0]  latch_reg, latch_next;
    logic [BYTE_W-1:0]  vector_reg, vector_next;
    logic [FRAME_W-1:0] frames_reg, frames_next;
    logic [FRAME_W-1:0] frames_inc;
    logic [BYTE_W-1:0]  dip_one_reg;
    logic [BYTE_W-1:0]  dip_two_reg;
    logic               wdog_on_reg;
    logic [RAM_ADDR_W-1:0] clear_cnt_reg;

    // Result register
    logic [BYTE_W-1:0] read_data_reg;
    logic              irq_reg;
    logic [BYTE_W-1:0] vec_out_reg;
    logic              cpu_reset_reg;
    logic [BYTE_W-1:0] latch_out_reg;

    // Memory ports
    logic [BYTE_W-1:0]     rom_rd_data;
    logic [BYTE_W-1:0]     ram_rd_data;
    logic                  rom_we;
    logic                  ram_we;
    logic [RAM_ADDR_W-1:0] ram_wr_addr;
    logic [BYTE_W-1:0]     ram_wr_data;

    // Decode
    logic [14:0]       addr15;
    logic              rom_hit;
    logic              in_ram;
    logic              in_window;
    logic              in_io;
    logic              is_write;
    logic              is_frame;
    logic              ram_we_exec;
    logic              latch_we;
    logic              kick;
    logic              vec_we;
    logic [BYTE_W-1:0] io_byte;
    logic [BYTE_W-1:0] rd_byte;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func;
            addr_reg  <= address;
            data_reg  <= write_data;
            joy_reg   <= joystick_port;
            start_reg <= start_port;
        end
    end

    // Program ROM: loaded through the request path, no reset
    abd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (ROM_BYTES)
    ) u_rom (
        .clk     (clk),
        .wr_en   (rom_we),
        .wr_addr (addr_reg[ROM_ADDR_W-1:0]),
        .wr_data (data_reg),
        .rd_en   (cmd.capture),
        .rd_addr (address[ROM_ADDR_W-1:0]),
        .rd_data (rom_rd_data)
    );

    // Work RAM: the clearing sweep shares the write port
    assign ram_we      = cmd.clear_step | (cmd.execute & ram_we_exec);
    assign ram_wr_addr = cmd.clear_step ? clear_cnt_reg : addr_reg[RAM_ADDR_W-1:0];
    assign ram_wr_data = cmd.clear_step ? '0 : data_reg;

    abd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_work_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.capture),
        .rd_addr (address[RAM_ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // Address decode with bit 15 masked
    assign addr15    = addr_reg[14:0];
    assign rom_hit   = ({1'b0, addr15} < ROM_LIMIT);
    assign in_ram    = (addr15[14:12] == 3'b100);
    assign in_window = in_ram && (addr15[11:10] == 2'b10);
    assign in_io     = (addr15[14:8] == 7'h50);
    assign is_write  = (func_reg == FUNC_WRITE);
    assign is_frame  = (func_reg == FUNC_FRAME);

    // Write targets; sound and sprite captures feed blocks outside this one
    assign ram_we_exec = is_write && in_ram && !in_window;
    assign latch_we    = is_write && in_io && (addr15[7:3] == 5'd0);
    assign kick        = is_write && in_io && (addr15[7:6] == 2'b11);
    assign vec_we      = (func_reg == FUNC_PORT) && (addr_reg[7:0] == 8'h00);
    assign rom_we      = cmd.execute && (func_reg == FUNC_ROM_LOAD) && (addr_reg < ROM_LIMIT);

    // Watchdog
    assign frames_inc       = frames_reg + 5'd1;
    assign stat.wdog_expire = is_frame && wdog_on_reg
                              && (frames_inc >= FRAME_W'(WATCHDOG_FRAMES));
    assign stat.clear_last  = &clear_cnt_reg;

    // Read data select
    always_comb
    begin
        case (abd_io_sel_t'(addr15[7:6]))
            IO_JOYSTICK: io_byte = joy_reg;
            IO_START:    io_byte = start_reg;
            IO_DIP_ONE:  io_byte = dip_one_reg;
            IO_DIP_TWO:  io_byte = dip_two_reg;
            default:     io_byte = dip_two_reg;
        endcase
        if (!addr15[14])
        begin
            rd_byte = rom_hit ? rom_rd_data : '0;
        end
        else if (in_ram)
        begin
            rd_byte = in_window ? UNMAPPED_BYTE : ram_rd_data;
        end
        else if (in_io)
        begin
            rd_byte = io_byte;
        end
        else
        begin
            rd_byte = UNMAPPED_BYTE;
        end
    end

    // Board state updates
    always_comb
    begin
        latch_next  = latch_reg;
        vector_next = vector_reg;
        frames_next = frames_reg;
        if (cmd.execute)
        begin
            if (latch_we)
            begin
                latch_next[addr15[2:0]] = data_reg[0];
            end
            if (vec_we)
            begin
                vector_next = data_reg;
            end
            if (kick)
            begin
                frames_next = '0;
            end
            if (is_frame && wdog_on_reg)
            begin
                frames_next = frames_inc;
            end
            if (stat.wdog_expire)
            begin
                latch_next  = '0;
                vector_next = '0;
                frames_next = '0;
            end
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg     <= '0;
            vector_reg    <= '0;
            frames_reg    <= '0;
            dip_one_reg   <= 8'hFF;
            dip_two_reg   <= 8'hFF;
            wdog_on_reg   <= 1'b1;
            clear_cnt_reg <= '0;
        end
        else
        begin
            latch_reg  <= latch_next;
            vector_reg <= vector_next;
            frames_reg <= frames_next;
            if (cmd.clear_step)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
            if (cfg_we)
            begin
                case (abd_cfg_t'(cfg_index))
                    CFG_DIP_ONE: dip_one_reg <= cfg_data;
                    CFG_DIP_TWO: dip_two_reg <= cfg_data;
                    CFG_WDOG_ON: wdog_on_reg <= cfg_data[0];
                    default:     ;
                endcase
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            read_data_reg <= (func_reg == FUNC_READ) ? rd_byte : '0;
            irq_reg       <= is_frame & latch_reg[0];
            vec_out_reg   <= vec_we ? data_reg : vector_reg;
            cpu_reset_reg <= stat.wdog_expire;
            latch_out_reg <= latch_next;
        end
    end

    assign read_data      = read_data_reg;
    assign irq_request    = irq_reg;
    assign irq_vector_out = vec_out_reg;
    assign cpu_reset      = cpu_reset_reg;
    assign latch_bits     = latch_out_reg;

`ifndef SYNTH
    // counter never reaches the expiry count
    a_frames_range: assert property (@(posedge clk) disable iff (!rst_n)
        frames_reg < FRAME_W'(WATCHDOG_FRAMES))
        else $error("abd_datapath: watchdog counter out of range");

    // expiry clears the latch and the vector
    a_expire_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && stat.wdog_expire) |=> (latch_reg == '0 && vector_reg == '0))
        else $error("abd_datapath: watchdog expiry left board state");

    // only bus reads return a data byte
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && (func_reg != FUNC_READ)) |=> (read_data == '0))
        else $error("abd_datapath: non-read transaction returned data");
`endif

endmodule

[rtl/arcade_board_bus_decoder.sv]
// ----------------------------------------------------------------------------
// arcade_board_bus_decoder
// Memory and I/O decoder of an 8-bit arcade board: ROM, work RAM, inputs,
// dip switches, addressable latch, interrupt vector and frame watchdog.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------------
//   in       | in_valid / in_ready   | func, address, write_data,
//            |                       | joystick_port, start_port
//   out      | out_valid / out_ready | read_data, irq_request, irq_vector_out,
//            |                       | cpu_reset, latch_bits
//   cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each transaction is captured with the ROM/RAM read issued, then executed
// against the registered read data. A result waiting in the output
// register holds execution of the next transaction; no new transaction
// is accepted meanwhile.
// After reset, and after each watchdog expiry, a sweep clears
// work RAM one entry a cycle with in_ready low; cfg writes are always taken.
// ----------------------------------------------------------------------------
module arcade_board_bus_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic [7:0]  joystick_port,
    input  logic [7:0]  start_port,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        irq_request,
    output logic [7:0]  irq_vector_out,
    output logic        cpu_reset,
    output logic [7:0]  latch_bits,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import abd_pkg::*;

    abd_cmd_t    cmd;
    abd_status_t stat;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    // Controller
    abd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Datapath
    abd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .func           (func),
        .address        (address),
        .write_data     (write_data),
        .joystick_port  (joystick_port),
        .start_port     (start_port),
        .read_data      (read_data),
        .irq_request    (irq_request),
        .irq_vector_out (irq_vector_out),
        .cpu_reset      (cpu_reset),
        .latch_bits     (latch_bits)
    );

endmodule

[tb/bus_decoder_checker.sv]
// ----------------------------------------------------------------------------
// bus_decoder_checker
// Watches the request, response and register channels of the arcade board
// bus decoder. Keeps its own image of ROM, work RAM, latch, vector and
// watchdog, works out the response of every accepted request, and compares
// each delivered response against the oldest one still awaited.
// ----------------------------------------------------------------------------
module bus_decoder_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  func,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic [7:0]  joystick_port,
    input  logic [7:0]  start_port,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  read_data,
    input  logic        irq_request,
    input  logic [7:0]  irq_vector_out,
    input  logic        cpu_reset,
    input  logic [7:0]  latch_bits,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          mismatches,
    output int          outstanding,
    output int          responses_checked,
    output int          watchdog_expiries
);
    timeunit 1ns;
    timeprecision 1ps;

    import abd_pkg::*;

    // Memory map boundaries, bit 15 already masked off
    localparam logic [14:0] RAM_BASE    = 15'h4000;
    localparam logic [14:0] HOLE_BASE   = 15'h4800;
    localparam logic [14:0] HOLE_END    = 15'h4C00;
    localparam logic [14:0] IO_BASE     = 15'h5000;
    localparam logic [14:0] LATCH_END   = 15'h5008;
    localparam logic [14:0] SOUND_BASE  = 15'h5040;
    localparam logic [14:0] SPRITE_BASE = 15'h5060;
    localparam logic [14:0] SPRITE_END  = 15'h5070;
    localparam logic [14:0] KICK_BASE   = 15'h50C0;
    localparam logic [14:0] IO_END      = 15'h5100;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic [7:0] vector;
        logic       reset;
        logic [7:0] latch;
    } response_t;

    // Board image
    logic [7:0]         rom_image   [ROM_BYTES];
    logic [7:0]         ram_image   [RAM_DEPTH];
    logic [7:0]         sound_image [32];
    logic [7:0]         sprite_regs [16];
    logic [7:0]         latch_q;
    logic [7:0]         vector_q;
    logic [FRAME_W-1:0] frames_q;
    logic [7:0]         dip_one_q;
    logic [7:0]         dip_two_q;
    logic               wdog_on_q;

    response_t awaited[$];
    response_t observed;
    response_t due;

    // RAM, captures, latch, vector and watchdog back to their power-up values
    function automatic void clear_board();
        for (int i = 0; i < RAM_DEPTH; i++)
            ram_image[i] = (i >= 'h800 && i < 'hC00) ? UNMAPPED_BYTE : 8'h00;
        for (int i = 0; i < 32; i++)
            sound_image[i] = 8'h00;
        for (int i = 0; i < 16; i++)
            sprite_regs[i] = 8'h00;
        latch_q  = 8'h00;
        vector_q = 8'h00;
        frames_q = '0;
    endfunction

    // Apply one request to the board image and return its response
    function automatic response_t decode_request(logic [2:0] f, logic [15:0] addr,
                                                 logic [7:0] wd, logic [7:0] joy,
                                                 logic [7:0] st);
        response_t   r;
        logic [14:0] a;
        r = '0;
        a = addr[14:0];
        case (f)
            FUNC_READ:
            begin
                if (a < RAM_BASE)
                begin
                    r.read_data = (a < ROM_BYTES) ? rom_image[a[ROM_ADDR_W-1:0]] : 8'h00;
                end
                else if (a < IO_BASE)
                begin
                    r.read_data = ram_image[a[RAM_ADDR_W-1:0]];
                end
                else if (a < IO_END)
                begin
                    case (abd_io_sel_t'(a[7:6]))
                        IO_JOYSTICK: r.read_data = joy;
                        IO_START:    r.read_data = st;
                        IO_DIP_ONE:  r.read_data = dip_one_q;
                        default:     r.read_data = dip_two_q;
                    endcase
                end
                else
                begin
                    r.read_data = UNMAPPED_BYTE;
                end
            end
            FUNC_WRITE:
            begin
                if (a >= RAM_BASE && a < IO_END)
                begin
                    if (a < IO_BASE)
                    begin
                        // the hole keeps reading its fixed byte
                        if (!(a >= HOLE_BASE && a < HOLE_END))
                            ram_image[a[RAM_ADDR_W-1:0]] = wd;
                    end
                    else if (a < LATCH_END)
                        latch_q[a[2:0]] = wd[0];
                    else if (a >= SOUND_BASE && a < SPRITE_BASE)
                        sound_image[a[4:0]] = wd;
                    else if (a >= SPRITE_BASE && a < SPRITE_END)
                        sprite_regs[a[3:0]] = wd;
                    else if (a >= KICK_BASE)
                        frames_q = '0;
                end
            end
            FUNC_PORT:
            begin
                if (addr[7:0] == 8'h00)
                    vector_q = wd;
            end
            FUNC_ROM_LOAD:
            begin
                if (addr < ROM_BYTES)
                    rom_image[addr[ROM_ADDR_W-1:0]] = wd;
            end
            default: ;
        endcase
        // vector goes out as it stood before any watchdog clear
        r.vector = vector_q;
        if (f == FUNC_FRAME)
        begin
            r.irq = latch_q[0];
            if (wdog_on_q)
            begin
                frames_q = frames_q + 1'b1;
                if (frames_q >= WATCHDOG_FRAMES)
                begin
                    clear_board();
                    r.reset = 1'b1;
                end
            end
        end
        r.latch = latch_q;
        return r;
    endfunction

    function automatic void note_mismatch(string what, response_t want, response_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t %s: expected rd=%h irq=%b vec=%h rst=%b latch=%h,",
                      " got rd=%h irq=%b vec=%h rst=%b latch=%h"},
                     $time, what, want.read_data, want.irq, want.vector, want.reset,
                     want.latch, got.read_data, got.irq, got.vector, got.reset, got.latch);
    endfunction

    // Channel monitor: register writes, responses, then new requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROM_BYTES; i++)
                rom_image[i] = 8'h00;
            clear_board();
            dip_one_q = 8'hFF;
            dip_two_q = 8'hFF;
            wdog_on_q = 1'b1;
            awaited.delete();
            mismatches = 0;
            responses_checked = 0;
            watchdog_expiries = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DIP_ONE: dip_one_q = cfg_data;
                    CFG_DIP_TWO: dip_two_q = cfg_data;
                    CFG_WDOG_ON: wdog_on_q = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                observed = {read_data, irq_request, irq_vector_out, cpu_reset, latch_bits};
                if (awaited.size() == 0)
                begin
                    note_mismatch("response with no request awaiting it", '0, observed);
                end
                else
                begin
                    due = awaited.pop_front();
                    responses_checked++;
                    if (due.reset)
                        watchdog_expiries++;
                    if (observed !== due)
                        note_mismatch("response mismatch", due, observed);
                end
            end
            if (in_valid && in_ready)
                awaited.push_back(decode_request(func, address, write_data,
                                                 joystick_port, start_port));
        end
        outstanding = awaited.size();
    end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Regression for the arcade board bus decoder: a directed pass over the
// memory map, then random request mixes under several idle and stall
// patterns, dip-switch and watchdog settings, and one long output hold-off.
// Responses are checked by bus_decoder_checker.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import abd_pkg::*;

    // Request codes the block treats as no-ops
    localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  func;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  joystick_port;
    logic [7:0]  start_port;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_data;
    logic        irq_request;
    logic [7:0]  irq_vector_out;
    logic        cpu_reset;
    logic [7:0]  latch_bits;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    int mismatches;
    int outstanding;
    int responses_checked;
    int watchdog_expiries;

    int requests_sent;
    int idle_pct;
    int stall_pct;
    bit pressure_phase;
    bit pressure_done;

    // ROM bytes loaded so far; reads of ROM only go to these
    bit          rom_filled [ROM_BYTES];
    logic [15:0] rom_offsets[$];

    arcade_board_bus_decoder dut (.*);

    bus_decoder_checker check_u (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("arcade_board_bus_decoder regression: fail");
        $finish;
    end

    // Response side: random stalls, plus one long hold-off in the pressure phase
    initial
    begin : receiver
        int held;
        out_ready = 1'b0;
        pressure_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_phase && !pressure_done)
            begin
                out_ready <= 1'b0;
                for (held = 0; held < 400; held++)
                    @(posedge clk);
                pressure_done = 1'b1;
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // One request transaction, with a random idle gap ahead of it
    task automatic send_item(logic [2:0] f, logic [15:0] a, logic [7:0] d,
                             logic [7:0] joy, logic [7:0] st);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= f;
        address       <= a;
        write_data    <= d;
        joystick_port <= joy;
        start_port    <= st;
        if (f == FUNC_ROM_LOAD && a < ROM_BYTES && !rom_filled[a[ROM_ADDR_W-1:0]])
        begin
            rom_filled[a[ROM_ADDR_W-1:0]] = 1'b1;
            rom_offsets.push_back(a);
        end
        requests_sent++;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(abd_cfg_t idx, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drain every awaited response, then a short tail
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (8)
            @(posedge clk);
    endtask

    // Work RAM offset: mostly a few hot spots in each quarter, hole included
    function automatic logic [15:0] ram_offset();
        if ($urandom_range(1))
            return 16'($urandom_range(3) * 'h400 + $urandom_range(7));
        return 16'($urandom_range('hFFF));
    endfunction

    task automatic send_random_request();
        int          pick;
        logic [15:0] a;
        logic [7:0]  d;
        logic [7:0]  joy;
        logic [7:0]  st;
        pick = $urandom_range(99);
        a    = 16'($urandom_range('hFFFF));
        d    = 8'($urandom_range('hFF));
        joy  = 8'($urandom_range('hFF));
        st   = 8'($urandom_range('hFF));
        if (pick < 34 || pick >= 94)
        begin
            case ($urandom_range(9))
                0, 1:    a = rom_offsets[$urandom_range(rom_offsets.size() - 1)];
                2, 3, 4: a = 16'h4000 | ram_offset();
                5, 6, 7: a = 16'h5000 | 16'($urandom_range('hFF));
                8:       a = 16'($urandom_range('h7FFF, 'h5100));
                default:
                begin
                    // stay clear of ROM bytes never loaded
                    if (a[14:0] < 15'h4000 && !rom_filled[a[ROM_ADDR_W-1:0]])
                        a[14] = 1'b1;
                end
            endcase
            a[15] = 1'($urandom_range(1));
            send_item(FUNC_READ, a, d, joy, st);
        end
        else if (pick < 64)
        begin
            case ($urandom_range(11))
                0, 1, 2: a = 16'h4000 | ram_offset();
                3, 4:    a = 16'h5000 | 16'($urandom_range(7));
                5:       a = 16'h5040 | 16'($urandom_range(31));
                6:       a = 16'h5060 | 16'($urandom_range(15));
                7:       a = 16'h50C0 | 16'($urandom_range(63));
                8:
                begin
                    // writes that land nowhere
                    case ($urandom_range(2))
                        0:       a = 16'($urandom_range('h503F, 'h5008));
                        1:       a = 16'($urandom_range('h50BF, 'h5070));
                        default: a = 16'($urandom_range('h7FFF, 'h5100));
                    endcase
                end
                9:       a = 16'($urandom_range('h3FFF));
                default: ;
            endcase
            a[15] = 1'($urandom_range(1));
            send_item(FUNC_WRITE, a, d, joy, st);
        end
        else if (pick < 70)
        begin
            if ($urandom_range(1))
                a[7:0] = 8'h00;
            send_item(FUNC_PORT, a, d, joy, st);
        end
        else if (pick < 78)
        begin
            send_item(FUNC_FRAME, a, d, joy, st);
        end
        else if (pick < 89)
        begin
            if ($urandom_range(4) != 0)
                a[15:14] = 2'b00;
            send_item(FUNC_ROM_LOAD, a, d, joy, st);
        end
        else if (pick < 90)
        begin
            // kick-free run of frames: expires the watchdog when it is on
            repeat (WATCHDOG_FRAMES)
                send_item(FUNC_FRAME, 16'($urandom_range('hFFFF)), 8'($urandom_range('hFF)),
                          8'($urandom_range('hFF)), 8'($urandom_range('hFF)));
        end
        else
        begin
            send_item(3'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST)),
                      a, d, joy, st);
        end
    endtask

    task automatic run_phase(int count, int idle, int stall, logic [7:0] dip_one,
                             logic [7:0] dip_two, logic wdog, bit hold);
        int target;
        settle();
        write_reg(CFG_DIP_ONE, dip_one);
        write_reg(CFG_DIP_TWO, dip_two);
        write_reg(CFG_WDOG_ON, {7'd0, wdog});
        idle_pct       = idle;
        stall_pct      = stall;
        pressure_phase = hold;
        target = requests_sent + count;
        while (requests_sent < target)
            send_random_request();
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        func           = FUNC_READ;
        address        = '0;
        write_data     = '0;
        joystick_port  = '0;
        start_port     = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_DIP_ONE;
        cfg_data       = '0;
        idle_pct       = 0;
        stall_pct      = 0;
        pressure_phase = 1'b0;
        requests_sent  = 0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass over the memory map
        run_phase(0, 0, 0, 8'h00, 8'hFF, 1'b1, 1'b0);
        send_item(FUNC_ROM_LOAD, 16'h0000, 8'hA5, 8'h00, 8'h00);
        send_item(FUNC_ROM_LOAD, 16'h3FFF, 8'h5A, 8'h00, 8'h00);
        send_item(FUNC_ROM_LOAD, 16'hFFFF, 8'h00, 8'h00, 8'h00);  // beyond ROM, dropped
        send_item(FUNC_READ,     16'h0000, 8'h00, 8'hFF, 8'hFF);
        send_item(FUNC_READ,     16'hBFFF, 8'h00, 8'hFF, 8'hFF);  // bit 15 masked
        send_item(FUNC_WRITE,    16'h0000, 8'h33, 8'h00, 8'h00);  // ROM not writable
        send_item(FUNC_READ,     16'h0000, 8'hFF, 8'h00, 8'h00);
        send_item(FUNC_WRITE,    16'h4000, 8'hFF, 8'h00, 8'h00);
        send_item(FUNC_WRITE,    16'hCFFF, 8'h01, 8'h00, 8'h00);
        send_item(FUNC_READ,     16'hC000, 8'h00, 8'h00, 8'h00);
        send_item(FUNC_WRITE,    16'h4800, 8'h12, 8'h00, 8'h00);  // hole
        send_item(FUNC_READ,     16'h4800, 8'h00, 8'h00, 8'h00);
        send_item(FUNC_WRITE,    16'h5000, 8'h01, 8'h00, 8'h00);  // irq mask on
        send_item(FUNC_WRITE,    16'h5007, 8'hFF, 8'h00, 8'h00);
        send_item(FUNC_WRITE,    16'h5007, 8'hFE, 8'h00, 8'h00);
        send_item(FUNC_READ,     16'h5000, 8'h00, 8'h00, 8'hFF);
        send_item(FUNC_READ,     16'h507F, 8'h00, 8'hFF, 8'h00);
        send_item(FUNC_READ,     16'h5080, 8'h00, 8'hFF, 8'hFF);
        send_item(FUNC_READ,     16'hD0FF, 8'h00, 8'h00, 8'h00);
        send_item(FUNC_READ,     16'h5100, 8'h00, 8'h00, 8'h00);  // above inputs
        send_item(FUNC_WRITE,    16'h5008, 8'hAA, 8'h00, 8'h00);  // dead write
        send_item(FUNC_PORT,     16'h0300, 8'hC3, 8'h00, 8'h00);
        send_item(FUNC_PORT,     16'h00FF, 8'h77, 8'h00, 8'h00);  // not port 0
        send_item(FUNC_FRAME,    16'h0000, 8'h00, 8'h00, 8'h00);
        send_item(FUNC_WRITE,    16'h50C0, 8'h00, 8'h00, 8'h00);  // watchdog kick
        send_item(FUNC_UNUSED_LAST, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(FUNC_READ,     16'h7FFF, 8'h00, 8'h00, 8'h00);

        // Random mixes
        run_phase(200, 0, 0, 8'hFF, 8'h00, 1'b1, 1'b0);
        run_phase(200, 69, 0, 8'($urandom_range('hFF)), 8'($urandom_range('hFF)),
                  1'b0, 1'b0);
        run_phase(200, 0, 69, 8'($urandom_range('hFF)), 8'($urandom_range('hFF)),
                  1'b1, 1'b0);
        run_phase(200, 30, 30, 8'h00, 8'h00, 1'b1, 1'b0);
        run_phase(100, 0, 0, 8'($urandom_range('hFF)), 8'($urandom_range('hFF)),
                  1'b1, 1'b1);
        run_phase(100, 30, 30, 8'hFF, 8'hFF, 1'b0, 1'b0);
        run_phase(175, $urandom_range(69), $urandom_range(69),
                  8'($urandom_range('hFF)), 8'($urandom_range('hFF)), 1'b1, 1'b0);
        settle();

        $display("Covered %0d requests across seven idle/stall mixes, %0d responses checked.",
                 requests_sent, responses_checked);
        $display("Watchdog expiries: %0d; long output hold-off %s.",
                 watchdog_expiries, pressure_done ? "done" : "missed");
        if (mismatches == 0 && outstanding == 0)
            $display("arcade_board_bus_decoder regression: pass");
        else
            $display("arcade_board_bus_decoder regression: fail");
        $finish;
    end

endmodule
